@@ rtl/swm_pkg.sv @@
// Shared types and constants of the sliding window maximum block.
package swm_pkg;

	// Width of one sample and of one result.
	localparam int DATA_W = 32;

	// Width of the window length register and of the sample count.
	localparam int CFG_W = 7;

	// Window length after reset.
	localparam logic [CFG_W-1:0] CFG_RESET = 7'd1;

	// Sequencer states: idle, front eviction, back pops with final append.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVICT,
		ST_POP
	} state_t;

endpackage

@@ rtl/sliding_window_maximum.sv @@
// Sliding window maximum over signed samples, built on a monotonic candidate deque in memory.
//
// Each accepted sample word is pushed into a ring of candidate maxima, tagged with its
// position. A word is worked on in steps: it is accepted, stale front candidates are
// dropped and smaller back candidates popped one at a time, and it is appended; each drop
// or pop is one read of the candidate memory, which has two registered read ports (one at
// the front, one at the back). Every sample is pushed once and popped at most once.
// smp_ready is high only between words. A result word waits in an output register, and
// only a second result that finds it still untaken stalls the block. Once window_size
// samples have arrived since the last word marked first, each sample yields the largest
// of the last window_size samples; a window_size of 0 acts as 1 and one above WINDOW_MAX
// acts as WINDOW_MAX. The window length is written through window_size_we; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module sliding_window_maximum #(
	parameter int unsigned WINDOW_MAX = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                window_size_we,
	input  logic [swm_pkg::CFG_W-1:0]           window_size_wdata,
	input  logic                                smp_valid,
	output logic                                smp_ready,
	input  logic signed [swm_pkg::DATA_W-1:0]   sample,
	input  logic                                first,
	output logic                                max_valid,
	input  logic                                max_ready,
	output logic signed [swm_pkg::DATA_W-1:0]   window_max
);

	localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int OCC_W   = $clog2(WINDOW_MAX + 1);
	localparam int POS_MOD = 2 * WINDOW_MAX;
	localparam int POS_W   = $clog2(POS_MOD);
	localparam int POS_W1  = POS_W + 1;
	localparam int ENT_W   = POS_W + swm_pkg::DATA_W;
	localparam int CMP_W   = (POS_W > swm_pkg::CFG_W) ? POS_W : swm_pkg::CFG_W;
	localparam int WIN_LIM_I = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;

	localparam logic [PTR_W-1:0]          PTR_LAST  = PTR_W'(WINDOW_MAX - 1);
	localparam logic [POS_W-1:0]          POS_LAST  = POS_W'(POS_MOD - 1);
	localparam logic [POS_W:0]            POS_MOD_V = POS_W1'(POS_MOD);
	localparam logic [swm_pkg::CFG_W-1:0] WIN_LIM   = swm_pkg::CFG_W'(WIN_LIM_I);

	swm_pkg::state_t state_q, state_d;

	logic [swm_pkg::CFG_W-1:0] win_q;
	logic [PTR_W-1:0]          head_q, head_d;
	logic [PTR_W-1:0]          tail_q, tail_d;
	logic [PTR_W-1:0]          back_addr;
	logic [OCC_W-1:0]          occ_q, occ_d;
	logic [POS_W-1:0]          pos_q, pos_d;
	logic [swm_pkg::CFG_W-1:0] seen_q, seen_d;
	logic signed [swm_pkg::DATA_W-1:0] sample_q;

	// Candidate memory: position tag above the sample value.
	logic [ENT_W-1:0] cand_mem [WINDOW_MAX];
	logic [ENT_W-1:0] rd_a_q;
	logic [ENT_W-1:0] rd_b_q;
	logic             mem_we;
	logic [ENT_W-1:0] mem_wdata;

	logic [swm_pkg::CFG_W-1:0]         win_eff;
	logic [POS_W-1:0]                  head_tag;
	logic [POS_W-1:0]                  age;
	logic signed [swm_pkg::DATA_W-1:0] head_val;
	logic signed [swm_pkg::DATA_W-1:0] back_val;
	logic                              evict_hit;
	logic                              pop_hit;
	logic [swm_pkg::CFG_W-1:0]         seen_sat;
	logic [swm_pkg::CFG_W-1:0]         seen_new;
	logic                              result;
	logic                              out_free;
	logic                              out_load;
	logic signed [swm_pkg::DATA_W-1:0] out_val;

	logic                              max_valid_q;
	logic signed [swm_pkg::DATA_W-1:0] max_q;

	// Window length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= swm_pkg::CFG_RESET;
		end else if (window_size_we) begin
			win_q <= window_size_wdata;
		end
	end

	// Window length in effect, clamped to the supported range.
	always_comb begin
		if (win_q == '0) begin
			win_eff = swm_pkg::CFG_W'(1);
		end else if (win_q > WIN_LIM) begin
			win_eff = WIN_LIM;
		end else begin
			win_eff = win_q;
		end
	end

	// Fields of the front and back candidates as read last cycle.
	assign head_tag = rd_a_q[ENT_W-1:swm_pkg::DATA_W];
	assign head_val = signed'(rd_a_q[swm_pkg::DATA_W-1:0]);
	assign back_val = signed'(rd_b_q[swm_pkg::DATA_W-1:0]);

	// Age of the front candidate, modulo the position range.
	always_comb begin
		if (pos_q >= head_tag) begin
			age = pos_q - head_tag;
		end else begin
			age = POS_W'({1'b0, pos_q} + POS_MOD_V - {1'b0, head_tag});
		end
	end

	assign evict_hit = (occ_q != '0) && (CMP_W'(age) >= CMP_W'(win_eff));
	assign pop_hit   = (occ_q != '0) && (sample_q > back_val);

	// Sample count after this sample, saturating at the window length.
	always_comb begin
		seen_sat = (seen_q > win_eff) ? win_eff : seen_q;
		seen_new = (seen_sat < win_eff) ? seen_sat + 1'b1 : seen_sat;
	end

	assign result   = (seen_new == win_eff);
	assign out_free = !max_valid_q || max_ready;

	// The front candidate is the new sample itself when all others are gone.
	assign out_val   = (occ_q == '0) ? sample_q : head_val;
	assign mem_wdata = {pos_q, sample_q};

	// Sequencer: one eviction or one pop per cycle, then the append, which a full output can hold.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		occ_d     = occ_q;
		pos_d     = pos_q;
		seen_d    = seen_q;
		mem_we    = 1'b0;
		out_load  = 1'b0;
		smp_ready = 1'b0;
		unique case (state_q)
			swm_pkg::ST_IDLE: begin
				smp_ready = 1'b1;
				if (smp_valid) begin
					if (first) begin
						head_d  = '0;
						tail_d  = '0;
						occ_d   = '0;
						seen_d  = '0;
						state_d = swm_pkg::ST_POP;
					end else if (evict_hit) begin
						head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
						occ_d   = occ_q - 1'b1;
						state_d = swm_pkg::ST_EVICT;
					end else begin
						state_d = swm_pkg::ST_POP;
					end
				end
			end
			swm_pkg::ST_EVICT: begin
				if (evict_hit) begin
					head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
					occ_d  = occ_q - 1'b1;
				end else begin
					state_d = swm_pkg::ST_POP;
				end
			end
			swm_pkg::ST_POP: begin
				if (pop_hit) begin
					tail_d = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;
					occ_d  = occ_q - 1'b1;
				end else if (!result || out_free) begin
					mem_we   = 1'b1;
					tail_d   = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
					occ_d    = occ_q + 1'b1;
					pos_d    = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
					seen_d   = seen_new;
					out_load = result;
					state_d  = swm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swm_pkg::ST_IDLE;
			end
		endcase
	end

	// Sequencer and deque control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swm_pkg::ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			pos_q   <= '0;
			seen_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			pos_q   <= pos_d;
			seen_q  <= seen_d;
		end
	end

	// Sample word held while it is worked on.
	always_ff @(posedge clk) begin
		if (smp_valid && smp_ready) begin
			sample_q <= sample;
		end
	end

	// Read addresses follow the next front and back, so data is ready in the next cycle.
	assign back_addr = (tail_d == '0) ? PTR_LAST : tail_d - 1'b1;

	// Candidate memory with two registered read ports and write forwarding.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cand_mem[tail_q] <= mem_wdata;
		end
		rd_a_q <= (mem_we && (tail_q == head_d)) ? mem_wdata : cand_mem[head_d];
		rd_b_q <= (mem_we && (tail_q == back_addr)) ? mem_wdata : cand_mem[back_addr];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_valid_q <= 1'b0;
		end else if (out_load) begin
			max_valid_q <= 1'b1;
		end else if (max_ready) begin
			max_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			max_q <= out_val;
		end
	end

	assign max_valid  = max_valid_q;
	assign window_max = max_q;

endmodule

@@ rtl/swm_checker.sv @@
// Port-level checks of the sliding window maximum block and their binding.
module swm_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                smp_valid,
	input logic                                smp_ready,
	input logic                                max_valid,
	input logic                                max_ready,
	input logic signed [swm_pkg::DATA_W-1:0]   window_max
);

	// A result word that is not taken stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		max_valid && !max_ready |=> max_valid && $stable(window_max))
	else $error("result word changed or dropped while stalled");

	// A sample word is not finished in its accept step, so ready drops after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready)
	else $error("sample word accepted on two consecutive cycles");

	// A new result comes from the append step, when no sample word is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(max_valid) |-> !$past(smp_ready))
	else $error("result word appeared outside the append step");

	// No new result appears on the cycle after a sample word is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && !max_valid |=> !max_valid)
	else $error("result word appeared right after an accept");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.smp_valid  (smp_valid),
	.smp_ready  (smp_ready),
	.max_valid  (max_valid),
	.max_ready  (max_ready),
	.window_max (window_max)
);
